// File: hw/rtl/bdq_pkg.sv
// Package for the bounded deque engine: mode, status and FSM types,
// port widths and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned DATA_BITS_DEF = 32;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP        = 2'd2,
    MODE_CLEAR      = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

// File: hw/rtl/bdq_if.sv
// Request and response channel interfaces of the bounded deque engine.
// Depends on bdq_pkg for the payload widths.
`timescale 1ns / 1ps

interface bdq_req_if;
  logic                         valid;
  logic                         ready;
  logic [bdq_pkg::MODE_W-1:0]   mode;
  logic [bdq_pkg::DATA_W-1:0]   data_in;

  modport source (output valid, mode, data_in, input ready);
  modport sink   (input valid, mode, data_in, output ready);
endinterface

interface bdq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [bdq_pkg::DATA_W-1:0]      popped_data;
  logic [bdq_pkg::DATA_W-1:0]      front_data;
  logic                            front_valid;
  logic [bdq_pkg::COUNT_OUT_W-1:0] count_out;
  logic [bdq_pkg::STATUS_W-1:0]    status;

  modport source (output valid, popped_data, front_data, front_valid, count_out, status,
                  input ready);
  modport sink   (input valid, popped_data, front_data, front_valid, count_out, status,
                  output ready);
endinterface

// File: hw/rtl/bounded_deque_engine_unit.sv
// A result is registered on its request transaction, but a pop that leaves entries
// behind first reads the new front word through the single store read port, and its
// result is completed in the read state. Throughput: one request per cycle while the
// response is taken, except such pops, which block requests during the read state.
// Reset: head, tail and count go to zero, no result pending; the store is not cleared
// and needs no clearing pass, since no entry is read before it is written.
`timescale 1ns / 1ps

module bounded_deque_engine_unit #(
  parameter int unsigned DEPTH     = bdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_BITS = bdq_pkg::DATA_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bdq_req_if.sink           req_i,
  bdq_rsp_if.source         rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] mem_rdata_q;
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_waddr, mem_raddr;

  bdq_pkg::state_e      state_q, state_d;
  logic [IW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]        count_q, count_d;
  logic [DATA_BITS-1:0] front_q, front_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic [bdq_pkg::DATA_W-1:0]      popped_q, front_out_q;
  logic                            fvalid_q;
  logic [bdq_pkg::COUNT_OUT_W-1:0] count_out_q;
  logic [bdq_pkg::STATUS_W-1:0]    status_q;

  logic                 accept, need_read, full, empty;
  bdq_pkg::mode_e       mode;
  bdq_pkg::status_e     status;
  logic [63:0]          in_wide, popped_wide, front_wide, rdata_wide;
  logic [DATA_BITS-1:0] word, popped_word;
  logic [31:0]          count_wide;
  logic [IW-1:0]        head_next, head_prev, tail_next;

  assign accept  = req_i.valid && req_i.ready;
  assign mode    = bdq_pkg::mode_e'(req_i.mode);
  assign in_wide = {32'd0, req_i.data_in};
  assign word    = in_wide[DATA_BITS-1:0];
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);

  assign head_next = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
  assign head_prev = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
  assign tail_next = (tail_q == IW'(DEPTH - 1)) ? '0 : tail_q + IW'(1);

  // Request decode: pointer, count and front updates plus store access
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    front_d     = front_q;
    status      = bdq_pkg::STAT_DONE;
    popped_word = '0;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_re      = 1'b0;
    mem_raddr   = head_next;
    need_read   = 1'b0;
    if (state_q == bdq_pkg::S_READ) begin
      front_d = mem_rdata_q;
    end else if (accept) begin
      case (mode)
        bdq_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            status = bdq_pkg::STAT_FULL;
          end else begin
            mem_we  = 1'b1;
            tail_d  = tail_next;
            count_d = count_q + CW'(1);
            if (empty) front_d = word;
          end
        end
        bdq_pkg::MODE_PUSH_FRONT: begin
          if (full) begin
            status = bdq_pkg::STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = head_prev;
            head_d    = head_prev;
            count_d   = count_q + CW'(1);
            front_d   = word;
          end
        end
        bdq_pkg::MODE_POP: begin
          if (empty) begin
            status = bdq_pkg::STAT_EMPTY;
          end else begin
            popped_word = front_q;
            head_d      = head_next;
            count_d     = count_q - CW'(1);
            // fetch the new front word unless the queue drains
            if (count_q != CW'(1)) begin
              mem_re    = 1'b1;
              need_read = 1'b1;
            end
          end
        end
        bdq_pkg::MODE_CLEAR: begin
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end
        default: begin
          status = bdq_pkg::STAT_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= word;
    if (mem_re) mem_rdata_q <= mem[mem_raddr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::S_IDLE: if (accept && need_read) state_d = bdq_pkg::S_READ;
      bdq_pkg::S_READ: state_d = bdq_pkg::S_IDLE;
      default:         state_d = bdq_pkg::S_IDLE;
    endcase
  end

  // Outputs of the FSM
  always_comb begin
    req_i.ready = 1'b0;
    rsp_valid_d = rsp_valid_q;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        req_i.ready = !rsp_valid_q || rsp_o.ready;
        if (accept)            rsp_valid_d = !need_read;
        else if (rsp_o.ready)  rsp_valid_d = 1'b0;
      end
      bdq_pkg::S_READ: rsp_valid_d = 1'b1;
      default:         rsp_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign popped_wide = 64'(popped_word);
  assign front_wide  = 64'(front_d);
  assign rdata_wide  = 64'(mem_rdata_q);
  assign count_wide  = 32'(count_d);

  // Result payload: load on transaction; the new front word is loaded in the read state
  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    if (state_q == bdq_pkg::S_READ) begin
      front_out_q <= rdata_wide[31:0];
    end else if (accept) begin
      popped_q    <= popped_wide[31:0];
      front_out_q <= (count_d != '0) ? front_wide[31:0] : '0;
      fvalid_q    <= (count_d != '0);
      count_out_q <= count_wide[bdq_pkg::COUNT_OUT_W-1:0];
      status_q    <= status;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.popped_data = popped_q;
  assign rsp_o.front_data  = front_out_q;
  assign rsp_o.front_valid = fvalid_q;
  assign rsp_o.count_out   = count_out_q;
  assign rsp_o.status      = status_q;

endmodule

// File: hw/rtl/bdq_checker.sv
// Port-level checker, bound into every bounded_deque_engine_unit instance.
// Depends on bdq_pkg for widths and status codes.
`timescale 1ns / 1ps

module bdq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [bdq_pkg::DATA_W-1:0]      popped_data_i,
  input logic [bdq_pkg::DATA_W-1:0]      front_data_i,
  input logic                            front_valid_i,
  input logic [bdq_pkg::COUNT_OUT_W-1:0] count_out_i,
  input logic [bdq_pkg::STATUS_W-1:0]    status_i
);

  // an empty queue shows no count and no front word
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !front_valid_i |-> count_out_i == '0 && front_data_i == '0)
    else $error("empty queue reports a count or a front word");

  // refused pop only on an empty queue, and nothing removed
  a_refused_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == bdq_pkg::STAT_EMPTY |->
      !front_valid_i && popped_data_i == '0)
    else $error("pop refused on a non-empty queue");

  // refused push only on a full, hence non-empty, queue
  a_refused_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == bdq_pkg::STAT_FULL |-> front_valid_i && popped_data_i == '0)
    else $error("push refused on a queue with room");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(popped_data_i) &&
      $stable(front_data_i) && $stable(count_out_i) && $stable(status_i))
    else $error("stalled response changed");

endmodule

bind bounded_deque_engine_unit bdq_checker u_bdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .popped_data_i (rsp_o.popped_data),
  .front_data_i  (rsp_o.front_data),
  .front_valid_i (rsp_o.front_valid),
  .count_out_i   (rsp_o.count_out),
  .status_i      (rsp_o.status)
);

// File: verif/bounded_deque_engine_unit_tb.sv
// Self-checking testbench for bounded_deque_engine_unit: push back/front, pop, clear.
// Depends on bdq_pkg and the request/response interfaces in bdq_if.sv.
`timescale 1ns / 1ps

module bounded_deque_engine_unit_tb;

  localparam int unsigned QDEPTH      = bdq_pkg::DEPTH_DEF;
  localparam int unsigned DW          = bdq_pkg::DATA_W;
  localparam int unsigned MW          = bdq_pkg::MODE_W;
  localparam int unsigned CNTW        = bdq_pkg::COUNT_OUT_W;
  localparam int unsigned STW         = bdq_pkg::STATUS_W;
  localparam int unsigned RANDOM_REQS = 630;
  localparam int unsigned STALL_LEN   = 300;
  localparam int unsigned DRAIN_SLACK = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    bdq_pkg::mode_e mode;
    logic [DW-1:0]  data;
  } request_t;

  typedef struct packed {
    logic [DW-1:0]   popped;
    logic [DW-1:0]   front;
    logic            front_valid;
    logic [CNTW-1:0] count;
    logic [STW-1:0]  status;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic          drv_valid = 1'b0;
  logic [MW-1:0] drv_mode  = '0;
  logic [DW-1:0] drv_data  = '0;
  logic          mon_ready = 1'b0;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  assign req_if.valid   = drv_valid;
  assign req_if.mode    = drv_mode;
  assign req_if.data_in = drv_data;
  assign rsp_if.ready   = mon_ready;

  bounded_deque_engine_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow deque state
  logic [DW-1:0] shadow_store [QDEPTH];
  int unsigned   shadow_head  = 0;
  int unsigned   shadow_tail  = 0;
  int unsigned   shadow_count = 0;

  request_t    pending_q[$];
  outcome_t    expected_q[$];
  request_t    offered;
  int unsigned n_items     = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_checked   = 0;
  int unsigned n_errors    = 0;
  int unsigned n_full      = 0;
  int unsigned n_empty     = 0;
  int unsigned n_clears    = 0;
  int unsigned stall_left  = 0;
  bit          stall_done  = 1'b0;
  int unsigned cycle_count = 0;
  logic        rsp_taken   = 1'b0;
  outcome_t    rsp_seen;

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    o = '0;
    o.status = bdq_pkg::STAT_DONE;
    case (r.mode)
      bdq_pkg::MODE_PUSH_BACK, bdq_pkg::MODE_PUSH_FRONT: begin
        if (shadow_count >= QDEPTH) begin
          o.status = bdq_pkg::STAT_FULL;
        end else if (r.mode == bdq_pkg::MODE_PUSH_BACK) begin
          shadow_store[shadow_tail] = r.data;
          shadow_tail = (shadow_tail + 1) % QDEPTH;
          shadow_count++;
        end else begin
          shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
          shadow_store[shadow_head] = r.data;
          shadow_count++;
        end
      end
      bdq_pkg::MODE_POP: begin
        if (shadow_count == 0) begin
          o.status = bdq_pkg::STAT_EMPTY;
        end else begin
          o.popped = shadow_store[shadow_head];
          shadow_head = (shadow_head + 1) % QDEPTH;
          shadow_count--;
        end
      end
      default: begin
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_count = 0;
      end
    endcase
    o.front_valid = (shadow_count != 0);
    o.front       = (shadow_count != 0) ? shadow_store[shadow_head] : '0;
    o.count       = CNTW'(shadow_count);
    return o;
  endfunction

  function automatic int traffic_phase();
    if (n_accepted < n_items / 3) return 0;
    if (n_accepted < (2 * n_items) / 3) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct();
    case (traffic_phase())
      0:       return 32;
      1:       return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (traffic_phase())
      0:       return 51;
      1:       return 32;
      default: return 0;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return DW'(1) << $urandom_range(DW - 1);
      default: return DW'($urandom);
    endcase
  endfunction

  // bias 0 fills, 1 drains, 2 balances
  function automatic bdq_pkg::mode_e pick_mode(int bias);
    int unsigned p;
    int unsigned pop_hi;
    p = $urandom_range(99);
    pop_hi = (bias == 0) ? 15 : (bias == 1) ? 80 : 52;
    if (p < 3) return bdq_pkg::MODE_CLEAR;
    if (p < pop_hi) return bdq_pkg::MODE_POP;
    return ($urandom_range(1) != 0) ? bdq_pkg::MODE_PUSH_FRONT : bdq_pkg::MODE_PUSH_BACK;
  endfunction

  task automatic add_item(bdq_pkg::mode_e m, logic [DW-1:0] d);
    request_t r;
    r.mode = m;
    r.data = d;
    pending_q.push_back(r);
  endtask

  task automatic report_failure(string msg);
    $display("[tb] FAILURE at cycle %0d: %s", cycle_count, msg);
    n_errors++;
  endtask

  // Driver: predict on every accepted request transaction, then offer the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (drv_valid && req_if.ready) begin
        expected_q.push_back(apply_request(offered));
        n_accepted <= n_accepted + 1;
      end
      // hold an offer that has not been taken yet
      if (!(drv_valid && !req_if.ready)) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          offered = pending_q.pop_front();
          drv_valid <= 1'b1;
          drv_mode  <= offered.mode;
          drv_data  <= offered.data;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once the idle-free phase starts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!stall_done && traffic_phase() == 2) begin
        stall_done <= 1'b1;
        stall_left <= STALL_LEN;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Monitor: capture response transactions at the edge, compare at the falling edge
  always @(posedge clk_i) begin
    rsp_taken <= rst_ni && rsp_if.valid && mon_ready;
    rsp_seen  <= '{popped: rsp_if.popped_data, front: rsp_if.front_data,
                   front_valid: rsp_if.front_valid, count: rsp_if.count_out,
                   status: rsp_if.status};
    if (rst_ni) begin
      mon_ready <= (stall_left == 0) && ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  always @(negedge clk_i) begin
    outcome_t want;
    if (rsp_taken) begin
      if (expected_q.size() == 0) begin
        report_failure("response with no request outstanding");
      end else begin
        want = expected_q.pop_front();
        if (rsp_seen.popped !== want.popped)
          report_failure($sformatf("popped_data %h, want %h", rsp_seen.popped, want.popped));
        if (rsp_seen.front !== want.front)
          report_failure($sformatf("front_data %h, want %h", rsp_seen.front, want.front));
        if (rsp_seen.front_valid !== want.front_valid)
          report_failure($sformatf("front_valid %b, want %b",
                                   rsp_seen.front_valid, want.front_valid));
        if (rsp_seen.count !== want.count)
          report_failure($sformatf("count_out %0d, want %0d", rsp_seen.count, want.count));
        if (rsp_seen.status !== want.status)
          report_failure($sformatf("status %0d, want %0d", rsp_seen.status, want.status));
        if (want.status == bdq_pkg::STAT_FULL) n_full++;
        if (want.status == bdq_pkg::STAT_EMPTY) n_empty++;
        n_checked <= n_checked + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[tb] timeout after %0d cycles", cycle_count);
      $display("[bounded_deque_engine_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned    n_rand;
    int unsigned    seg_len;
    int             bias;
    bdq_pkg::mode_e m;

    // Directed: empty pops, data extremes, front pushes wrapping the head, clears
    add_item(bdq_pkg::MODE_POP,        32'hDEAD_BEEF);
    add_item(bdq_pkg::MODE_PUSH_BACK,  32'h0000_0000);
    add_item(bdq_pkg::MODE_PUSH_BACK,  32'hFFFF_FFFF);
    add_item(bdq_pkg::MODE_POP,        32'h0000_0000);
    add_item(bdq_pkg::MODE_POP,        32'hFFFF_FFFF);
    add_item(bdq_pkg::MODE_POP,        32'h0000_0000);
    add_item(bdq_pkg::MODE_PUSH_FRONT, 32'h1234_5678);
    add_item(bdq_pkg::MODE_PUSH_FRONT, 32'hA5A5_A5A5);
    add_item(bdq_pkg::MODE_PUSH_BACK,  32'h5A5A_5A5A);
    add_item(bdq_pkg::MODE_POP,        32'hFFFF_FFFF);
    add_item(bdq_pkg::MODE_POP,        32'h0000_0000);
    add_item(bdq_pkg::MODE_CLEAR,      32'hFFFF_FFFF);
    add_item(bdq_pkg::MODE_POP,        32'h0000_0000);
    add_item(bdq_pkg::MODE_CLEAR,      32'h0000_0000);
    add_item(bdq_pkg::MODE_PUSH_BACK,  32'h8000_0000);
    add_item(bdq_pkg::MODE_PUSH_FRONT, 32'h0000_0001);
    add_item(bdq_pkg::MODE_CLEAR,      32'h0000_0000);
    add_item(bdq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF);
    add_item(bdq_pkg::MODE_POP,        32'h0000_0000);
    add_item(bdq_pkg::MODE_POP,        32'h0000_0000);

    // Random: segments that fill, drain or churn the deque
    n_rand = 0;
    while (n_rand < RANDOM_REQS) begin
      seg_len = $urandom_range(110, 30);
      if (seg_len > RANDOM_REQS - n_rand) seg_len = RANDOM_REQS - n_rand;
      bias = $urandom_range(2);
      repeat (seg_len) begin
        m = pick_mode(bias);
        add_item(m, rand_word());
        n_rand++;
      end
    end
    n_items = pending_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_items || n_checked != n_accepted) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_failure($sformatf("%0d responses never arrived", expected_q.size()));

    $display("[tb] %0d requests, %0d responses checked over three idle profiles",
             n_accepted, n_checked);
    $display("[tb] refused on full: %0d, refused on empty: %0d, receiver hold-off %0d cycles",
             n_full, n_empty, STALL_LEN);
    if (n_errors == 0) begin
      $display("[bounded_deque_engine_unit] OK");
    end else begin
      $display("[bounded_deque_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: bounded_deque_engine_unit.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_if.sv
hw/rtl/bounded_deque_engine_unit.sv
hw/rtl/bdq_checker.sv
verif/bounded_deque_engine_unit_tb.sv
